// ----- hw/rtl/lgu_pkg.sv -----
package lgu_pkg;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_e;

  typedef struct packed {
    logic        start;
    alu_op_e     op;
    logic [63:0] opa;
    logic [31:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } alu_rsp_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISP,
    ST_WAIT,
    ST_SQ_FIN,
    ST_HUB_IN,
    ST_HUB_DA,
    ST_HUB_DD,
    ST_LNORM,
    ST_LSQ,
    ST_LSQR,
    ST_LNEG,
    ST_LLO,
    ST_LHI,
    ST_PH_Q,
    ST_PH_QQ,
    ST_PH_RT,
    ST_PH_G,
    ST_PH_AR,
    ST_PH_V,
    ST_ACC,
    ST_MEAN,
    ST_OUT
  } lgu_state_e;

  // Loss kinds.
  localparam logic [2:0] KindLog    = 3'd0;
  localparam logic [2:0] KindSquare = 3'd1;
  localparam logic [2:0] KindAbs    = 3'd2;
  localparam logic [2:0] KindHuber  = 3'd3;
  localparam logic [2:0] KindPseudo = 3'd4;

  // Register indexes.
  localparam logic CfgLossKind   = 1'b0;
  localparam logic CfgHuberDelta = 1'b1;

  localparam logic [47:0] SumMax  = 48'hFFFF_FFFF_FFFF;
  localparam logic [30:0] MeanMax = 31'h7FFF_FFFF;
  localparam logic [31:0] Ln2Q28  = 32'd186065279;
  localparam logic [31:0] RootOne = 32'h8000_0000;
  localparam logic [63:0] SqrtBias = 64'h4000_0000_0000_0000;

endpackage

// ----- hw/rtl/lgu_alu.sv -----
module lgu_alu import lgu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  alu_op_e     op_q;
  logic [63:0] acc_q, aux_q, bit_q, res_q;
  logic [31:0] rem_q, dvs_q;

  logic        last_step;
  logic [63:0] prod;
  logic [32:0] div_sh;
  logic [33:0] div_diff;
  logic        div_ge;
  logic [31:0] div_rem_nxt;
  logic [63:0] div_acc_nxt;
  logic [64:0] sq_trial;
  logic        sq_ge;
  logic [63:0] sq_acc_nxt, sq_aux_nxt;

  assign prod = req_i.opa[31:0] * req_i.opb;

  // Restoring division, one quotient bit per cycle.
  assign div_sh      = {rem_q, acc_q[63]};
  assign div_diff    = {1'b0, div_sh} - {2'b00, dvs_q};
  assign div_ge      = !div_diff[33];
  assign div_rem_nxt = div_ge ? div_diff[31:0] : div_sh[31:0];
  assign div_acc_nxt = {acc_q[62:0], div_ge};

  // Digit-by-digit square root, one result bit per cycle.
  assign sq_trial   = {1'b0, aux_q} + {1'b0, bit_q};
  assign sq_ge      = {1'b0, acc_q} >= sq_trial;
  assign sq_acc_nxt = sq_ge ? acc_q - sq_trial[63:0] : acc_q;
  assign sq_aux_nxt = sq_ge ? (aux_q >> 1) + bit_q : aux_q >> 1;

  assign last_step = (op_q == ALU_DIV) ? (cnt_q == 6'd63) : (cnt_q == 6'd31);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ALU_MUL;
    end else if (req_i.start) begin
      busy_q <= (req_i.op != ALU_MUL);
      done_q <= (req_i.op == ALU_MUL);
      cnt_q  <= '0;
      op_q   <= req_i.op;
    end else if (busy_q) begin
      cnt_q  <= cnt_q + 6'd1;
      busy_q <= !last_step;
      done_q <= last_step;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      unique case (req_i.op)
        ALU_MUL: res_q <= prod;
        ALU_DIV: begin
          acc_q <= req_i.opa;
          rem_q <= '0;
          dvs_q <= req_i.opb;
        end
        ALU_SQRT: begin
          acc_q <= req_i.opa;
          aux_q <= '0;
          bit_q <= SqrtBias;
        end
        default: res_q <= prod;
      endcase
    end else if (busy_q) begin
      if (op_q == ALU_DIV) begin
        acc_q <= div_acc_nxt;
        rem_q <= div_rem_nxt;
        if (last_step) res_q <= div_acc_nxt;
      end else begin
        acc_q <= sq_acc_nxt;
        aux_q <= sq_aux_nxt;
        bit_q <= bit_q >> 2;
        if (last_step) res_q <= sq_aux_nxt;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

// ----- hw/rtl/loss_and_gradient_unit.sv -----
// Loss and gradient unit. Each item carries a (target, prediction) pair in signed fixed point
// with FRAC_BITS fraction bits, a last flag and the batch row count; each item yields one
// result item holding the saturated loss gradient of that element. The element's loss is
// added to a saturating 48-bit accumulator, and on the item marked last the result also
// carries the mean loss (sum divided by the row count, saturated to 31 bits) with the tuser
// flag set, after which the accumulator clears. The user must write the loss kind and Huber
// delta registers through the plain write port while the unit is idle; the unit itself does
// not enforce this. The unit works on one item at a time: a small sequencer drives a single
// shared unit that multiplies 32 by 32 bits, divides a 64-bit value by a 32-bit divisor and
// takes a 64-bit square root. Log loss uses bit-wise normalisation plus 30 squaring steps,
// pseudo-Huber loss up to three divisions and one root, and the item marked last adds a
// division for the mean. The result waits in an output register, so the next item is taken
// while it is still pending.
module loss_and_gradient_unit import lgu_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] target, [63:32] prediction, [79:64] batch_rows
  input  logic [79:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] gradient, [62:32] mean_loss, [63] zero
  output logic [63:0] m_axis_tdata_o,
  // [0] loss_valid
  output logic        m_axis_tuser_o
);

  localparam logic [31:0] OneQ       = 32'(64'd1 << FRAC_BITS);
  localparam logic [30:0] DeltaReset = 31'(64'd1 << FRAC_BITS);

  lgu_state_e state_q, state_d, ret_q, ret_d;
  alu_req_t   req;
  alu_rsp_t   rsp;

  logic [2:0]  kind_q;
  logic [30:0] delta_q;
  logic [47:0] sum_q;
  logic        out_valid_q, out_user_q;
  logic [63:0] out_data_q;

  logic [31:0]        t_q, p_q, a_q, x_q, root_q;
  logic               last_q;
  logic [15:0]        rows_q;
  logic signed [32:0] e_q;
  logic [30:0]        d_q, mean_q;
  logic signed [34:0] g_q;
  logic [47:0]        l_q;
  logic [63:0]        tmp_q;
  logic [4:0]         k_q, cnt_q;
  logic [29:0]        frac_q;
  logic [34:0]        neg_q;

  logic               accept, out_free, a_le_d;
  logic signed [32:0] e_in;
  logic [31:0]        n_val, m_val, y_sq;
  logic [48:0]        sum_ext;
  logic [47:0]        sum_new;
  logic [15:0]        rows_div;
  logic signed [36:0] l2, neg;
  logic [63:0]        log_full, log_v, ph_v;
  logic [32:0]        ph_mag;
  logic [31:0]        g_sat;

  function automatic logic [47:0] cap_sum(input logic [63:0] v);
    cap_sum = (v > 64'(SumMax)) ? SumMax : v[47:0];
  endfunction

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign e_in = $signed({s_axis_tdata_i[63], s_axis_tdata_i[63:32]})
              - $signed({s_axis_tdata_i[31], s_axis_tdata_i[31:0]});

  assign a_le_d = a_q <= {1'b0, d_q};
  assign n_val  = a_le_d ? a_q : {1'b0, d_q};
  assign m_val  = a_le_d ? {1'b0, d_q} : a_q;

  assign sum_ext  = {1'b0, sum_q} + {1'b0, l_q};
  assign sum_new  = sum_ext[48] ? SumMax : sum_ext[47:0];
  assign rows_div = (rows_q == 16'd0) ? 16'd1 : rows_q;

  // Squaring step of the log2 fraction: x*x scaled back by 2^30.
  assign y_sq = rsp.res[61:30];

  // Log2 of the prediction and its negation, with 30 fraction bits.
  assign l2  = ((37'(k_q) - 37'(FRAC_BITS)) <<< 30) + 37'(frac_q);
  assign neg = -l2;

  assign log_full = tmp_q + {rsp.res[31:0], 32'h0};
  assign log_v    = log_full >> (58 - FRAC_BITS);
  assign ph_v     = rsp.res >> (31 - FRAC_BITS);
  assign ph_mag   = rsp.res[32:0];

  assign g_sat = (g_q > 35'sh0_7FFF_FFFF)  ? 32'h7FFF_FFFF :
                 (g_q < -35'sh0_8000_0000) ? 32'h8000_0000 : g_q[31:0];

  // Sequencer: next state and requests to the shared unit.
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    req.start = 1'b0;
    req.op    = ALU_MUL;
    req.opa   = '0;
    req.opb   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_DISP;
      end
      ST_DISP: begin
        unique case (kind_q)
          KindLog: begin
            if (t_q == OneQ && !p_q[31] && p_q != 32'd0) state_d = ST_LNORM;
            else state_d = ST_ACC;
          end
          KindSquare: begin
            req.start = 1'b1;
            req.opa   = 64'(a_q);
            req.opb   = a_q;
            ret_d     = ST_SQ_FIN;
            state_d   = ST_WAIT;
          end
          KindHuber: begin
            req.start = 1'b1;
            req.opa   = a_le_d ? 64'(a_q) : 64'(d_q);
            req.opb   = a_q;
            ret_d     = a_le_d ? ST_HUB_IN : ST_HUB_DA;
            state_d   = ST_WAIT;
          end
          KindPseudo: begin
            req.start = 1'b1;
            req.op    = ALU_DIV;
            req.opa   = 64'(n_val) << 31;
            req.opb   = m_val;
            ret_d     = ST_PH_Q;
            state_d   = ST_WAIT;
          end
          default: state_d = ST_ACC;
        endcase
      end
      ST_WAIT: begin
        if (rsp.done) state_d = ret_q;
      end
      ST_SQ_FIN, ST_HUB_IN, ST_HUB_DD, ST_LHI, ST_PH_V: state_d = ST_ACC;
      ST_HUB_DA: begin
        req.start = 1'b1;
        req.opa   = 64'(d_q);
        req.opb   = 32'(d_q);
        ret_d     = ST_HUB_DD;
        state_d   = ST_WAIT;
      end
      ST_LNORM: begin
        if (k_q == 5'd0 || x_q[30]) state_d = ST_LSQ;
      end
      ST_LSQ: begin
        req.start = 1'b1;
        req.opa   = 64'(x_q);
        req.opb   = x_q;
        ret_d     = ST_LSQR;
        state_d   = ST_WAIT;
      end
      ST_LSQR: begin
        state_d = (cnt_q == 5'd29) ? ST_LNEG : ST_LSQ;
      end
      ST_LNEG: begin
        if (neg[36] || neg == 37'sd0) begin
          state_d = ST_ACC;
        end else begin
          req.start = 1'b1;
          req.opa   = 64'(neg[31:0]);
          req.opb   = Ln2Q28;
          ret_d     = ST_LLO;
          state_d   = ST_WAIT;
        end
      end
      ST_LLO: begin
        req.start = 1'b1;
        req.opa   = 64'(neg_q[34:32]);
        req.opb   = Ln2Q28;
        ret_d     = ST_LHI;
        state_d   = ST_WAIT;
      end
      ST_PH_Q: begin
        req.start = 1'b1;
        req.opa   = 64'(rsp.res[31:0]);
        req.opb   = rsp.res[31:0];
        ret_d     = ST_PH_QQ;
        state_d   = ST_WAIT;
      end
      ST_PH_QQ: begin
        req.start = 1'b1;
        req.op    = ALU_SQRT;
        req.opa   = SqrtBias + rsp.res;
        ret_d     = ST_PH_RT;
        state_d   = ST_WAIT;
      end
      ST_PH_RT: begin
        req.start = 1'b1;
        req.op    = ALU_DIV;
        req.opa   = 64'(n_val) << 31;
        req.opb   = rsp.res[31:0];
        ret_d     = ST_PH_G;
        state_d   = ST_WAIT;
      end
      ST_PH_G: begin
        if (a_le_d) begin
          state_d = ST_ACC;
        end else begin
          req.start = 1'b1;
          req.opa   = 64'(a_q);
          req.opb   = root_q;
          ret_d     = ST_PH_AR;
          state_d   = ST_WAIT;
        end
      end
      ST_PH_AR: begin
        req.start = 1'b1;
        req.op    = ALU_DIV;
        req.opa   = rsp.res;
        req.opb   = 32'(d_q);
        ret_d     = ST_PH_V;
        state_d   = ST_WAIT;
      end
      ST_ACC: begin
        if (last_q) begin
          req.start = 1'b1;
          req.op    = ALU_DIV;
          req.opa   = 64'(sum_new);
          req.opb   = 32'(rows_div);
          ret_d     = ST_MEAN;
          state_d   = ST_WAIT;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_MEAN: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, configuration and the running sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      kind_q      <= KindSquare;
      delta_q     <= DeltaReset;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgLossKind) kind_q <= cfg_wdata_i[2:0];
        else delta_q <= cfg_wdata_i;
      end
      if (state_q == ST_ACC) sum_q <= last_q ? '0 : sum_new;
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  // Item datapath.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          t_q    <= s_axis_tdata_i[31:0];
          p_q    <= s_axis_tdata_i[63:32];
          rows_q <= s_axis_tdata_i[79:64];
          last_q <= s_axis_tlast_i;
          e_q    <= e_in;
          a_q    <= e_in[32] ? 32'(-e_in) : e_in[31:0];
          d_q    <= (delta_q == 31'd0) ? 31'd1 : delta_q;
        end
      end
      ST_DISP: begin
        l_q <= '0;
        x_q <= p_q;
        k_q <= 5'd30;
        unique case (kind_q)
          KindLog: begin
            g_q <= 35'(e_q);
            // A prediction that is not positive gives the largest loss.
            if (t_q == OneQ && (p_q[31] || p_q == 32'd0)) l_q <= 48'(MeanMax);
          end
          KindSquare: g_q <= 35'(e_q) <<< 1;
          KindAbs: begin
            l_q <= 48'(a_q);
            if (e_q == 33'sd0) g_q <= '0;
            else if (e_q[32]) g_q <= -35'(OneQ);
            else g_q <= 35'(OneQ);
          end
          KindHuber: begin
            if (a_le_d) g_q <= 35'(e_q);
            else if (e_q[32]) g_q <= -35'(d_q);
            else g_q <= 35'(d_q);
          end
          default: g_q <= '0;
        endcase
      end
      ST_SQ_FIN: l_q <= cap_sum(rsp.res >> FRAC_BITS);
      ST_HUB_IN: l_q <= cap_sum(rsp.res >> (FRAC_BITS + 1));
      ST_HUB_DA: tmp_q <= rsp.res;
      ST_HUB_DD: l_q <= cap_sum((tmp_q - (rsp.res >> 1)) >> FRAC_BITS);
      ST_LNORM: begin
        if (k_q != 5'd0 && !x_q[30]) begin
          x_q <= x_q << 1;
          k_q <= k_q - 5'd1;
        end else begin
          cnt_q  <= '0;
          frac_q <= '0;
        end
      end
      ST_LSQR: begin
        frac_q <= {frac_q[28:0], y_sq[31]};
        x_q    <= y_sq[31] ? {1'b0, y_sq[31:1]} : y_sq;
        cnt_q  <= cnt_q + 5'd1;
      end
      ST_LNEG: begin
        neg_q <= neg[34:0];
        // A prediction of one or above gives the smallest loss.
        l_q   <= 48'd1;
      end
      ST_LLO: tmp_q <= rsp.res;
      ST_LHI: begin
        if (log_v == 64'd0) l_q <= 48'd1;
        else if (log_v > 64'(MeanMax)) l_q <= 48'(MeanMax);
        else l_q <= log_v[47:0];
      end
      ST_PH_RT: root_q <= rsp.res[31:0];
      ST_PH_G: begin
        g_q <= e_q[32] ? -35'(ph_mag) : 35'(ph_mag);
        l_q <= 48'((root_q - RootOne) >> (31 - FRAC_BITS));
      end
      ST_PH_V: l_q <= cap_sum(ph_v - (64'd1 << FRAC_BITS));
      ST_ACC: mean_q <= '0;
      ST_MEAN: mean_q <= (rsp.res > 64'(MeanMax)) ? MeanMax : rsp.res[30:0];
      ST_OUT: begin
        if (out_free) begin
          out_data_q <= {1'b0, mean_q, g_sat};
          out_user_q <= last_q;
        end
      end
      default: tmp_q <= tmp_q;
    endcase
  end

  lgu_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // The shared unit only reports a finished operation while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rsp.done |-> state_q == ST_WAIT)
    else $error("shared unit finished outside a wait");

  // An accepted item keeps the input closed until its result is under way.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("input reopened while an item is in work");

  // A result without the batch flag carries no mean loss.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> m_axis_tdata_o[63:32] == 32'd0)
    else $error("mean loss given outside the last item");

  // A new request is never issued while an earlier one is still being waited for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) |-> !req.start)
    else $error("request issued during a wait");

endmodule
